// ===== src/swgl_pkg.sv =====
`default_nettype none

package swgl_pkg;

  // log2(e) in q32, split into its low word and a single top bit
  localparam logic [32:0] LOG2E_FIX = 33'd6196328018;

  localparam int EXP_STEPS = 32;
  localparam int DIV_STEPS = 33;

  localparam logic [63:0] EXP2_FRAC [EXP_STEPS] = '{
    64'h6A09E667F3BCC908, 64'h306FE0A31B7152DE, 64'h172B83C7D517ADCD, 64'h0B5586CF9890F629,
    64'h059B0D31585743AE, 64'h02C9A3E778060EE6, 64'h0163DA9FB33356D7, 64'h00B1AFA5ABCBED60,
    64'h0058C86DA1C09EA1, 64'h002C605E2E8CEC4F, 64'h00162F3904051FA0, 64'h000B175EFFDC76B9,
    64'h00058BA01FB9F96C, 64'h0002C5CC37DA9491, 64'h000162E525EE0546, 64'h0000B17255775C03,
    64'h000058B91B5BC9AD, 64'h00002C5C89D5EC6C, 64'h0000162E43F4F830, 64'h00000B1721BCFC99,
    64'h0000058B90CF1E6D, 64'h000002C5C863B73E, 64'h00000162E430E5A1, 64'h000000B172183551,
    64'h00000058B90C0B48, 64'h0000002C5C8601CC, 64'h000000162E42FFF0, 64'h0000000B17217FBA,
    64'h000000058B90BFCD, 64'h00000002C5C85FE2, 64'h0000000162E42FF0, 64'h00000000B17217F7
  };

  // fields that ride along the whole pipeline
  typedef struct packed {
    logic        last;
    logic        zerr;
    logic        zneg;
    logic        uneg;
    logic [62:0] zmag;
    logic [63:0] umag;
  } cmn_t;

  // exponential kernel state
  typedef struct packed {
    logic [31:0] f;
    logic [4:0]  negn;
    logic        uf;
    logic        one;
    logic [63:0] acc;
  } ex_t;

  // restoring divider state
  typedef struct packed {
    logic [65:0] rem;
    logic [33:0] d;
    logic [32:0] q;
  } dv_t;

  // 32x32 partial products of a 64x64 multiply
  typedef struct packed {
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } pp_t;

  function automatic pp_t mul_parts(input logic [63:0] a, input logic [63:0] b);
    pp_t p;
    p.p00 = {32'd0, a[31:0]}  * {32'd0, b[31:0]};
    p.p01 = {32'd0, a[31:0]}  * {32'd0, b[63:32]};
    p.p10 = {32'd0, a[63:32]} * {32'd0, b[31:0]};
    p.p11 = {32'd0, a[63:32]} * {32'd0, b[63:32]};
    return p;
  endfunction

  function automatic logic [127:0] pp_sum(input pp_t p);
    return {64'd0, p.p00} + {32'd0, p.p01, 32'd0} + {32'd0, p.p10, 32'd0} + {p.p11, 64'd0};
  endfunction

endpackage

`default_nettype wire

// ===== src/swiglu_gate_fixed_point.sv =====
`default_nettype none
// swiglu gate element, signed q24 in and out: gated = silu(gate) * up
// input channel: in_valid/in_ready carry in_gate_value, in_up_value and
//   in_last_element; a beat is taken when both are high
// output channel: out_valid/out_ready carry out_gated_value, out_range_error
//   and out_last_out; one result beat for every input beat, in order
// pipeline: 107 register stages from the taken input beat to out_valid:
//   two stages for the log2e multiply, one to split y
//   into fraction and shift, 32 double stages of the 2^(2^-k) product chain,
//   one to scale by the integer part, one to set up the divider, 33
//   restoring divider stages and five for the two final multiplies
// throughput: one beat per cycle while the receiver takes results, set by the
//   fully unrolled product chain and divider, every stage holding one element
// range_error flags a gate of -2^63 or a result beyond +-(2^63-1); the
//   value is then 0
// reset clears all stage valid bits; payload registers are not reset
// when the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready drops, so nothing is lost or repeated
// last_out is simply carried along with its element

module swiglu_gate_fixed_point (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [63:0] in_gate_value,
  input  wire logic signed [63:0] in_up_value,
  input  wire logic               in_last_element,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [63:0]      out_gated_value,
  output logic                    out_range_error,
  output logic                    out_last_out
);

  // stage map
  localparam int ST_S1   = 0;
  localparam int ST_S2   = ST_S1 + 1;
  localparam int ST_S3   = ST_S2 + 1;
  localparam int ST_LOOP = ST_S3 + 1;
  localparam int ST_E    = ST_LOOP + 2 * swgl_pkg::EXP_STEPS;
  localparam int ST_DI   = ST_E + 1;
  localparam int ST_DIV  = ST_DI + 1;
  localparam int ST_M1   = ST_DIV + swgl_pkg::DIV_STEPS;
  localparam int ST_M2   = ST_M1 + 1;
  localparam int ST_M3   = ST_M2 + 1;
  localparam int ST_M4   = ST_M3 + 1;
  localparam int ST_M5   = ST_M4 + 1;
  localparam int NST     = ST_M5 + 1;

  logic                 adv;
  logic [NST-1:0]       vld_r;
  swgl_pkg::cmn_t       cm_r [NST];
  swgl_pkg::cmn_t       cm_in;

  // the whole pipe moves unless a finished result is held up
  assign adv      = !vld_r[NST-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // input decode: sign and magnitude
  logic [63:0] zmag_w;
  logic [63:0] umag_w;
  assign zmag_w = in_gate_value[63] ? (64'd0 - in_gate_value) : in_gate_value;
  assign umag_w = in_up_value[63] ? (64'd0 - in_up_value) : in_up_value;

  always_comb begin
    cm_in.last = in_last_element;
    cm_in.zerr = (in_gate_value == {1'b1, 63'd0});
    cm_in.zneg = in_gate_value[63];
    cm_in.uneg = in_up_value[63];
    cm_in.zmag = zmag_w[62:0];
    cm_in.umag = umag_w;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cm_r[0] <= cm_in;
      for (int s = 1; s < NST; s++) begin
        cm_r[s] <= cm_r[s-1];
      end
    end
  end

  // stage s1: (mag << 8) * log2e, partial products
  logic [37:0] x_w;
  logic [63:0] px0_r;
  logic [37:0] px1_r;
  logic [37:0] x_r;
  logic        uf1_r;
  assign x_w = {zmag_w[29:0], 8'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      px0_r <= {32'd0, x_w[31:0]} * {32'd0, swgl_pkg::LOG2E_FIX[31:0]};
      px1_r <= {32'd0, x_w[37:32]} * {6'd0, swgl_pkg::LOG2E_FIX[31:0]};
      x_r   <= x_w;
      // magnitude of 2^30 or more underflows the exponential
      uf1_r <= (zmag_w[63:30] != 34'd0);
    end
  end

  // stage s2: m = ceil(product / 2^32)
  logic [71:0] full_w;
  logic [38:0] m_r;
  logic        uf2_r;
  assign full_w = {2'd0, px1_r, 32'd0} + {2'd0, x_r, 32'd0} + {8'd0, px0_r}
                + {40'd0, 32'hFFFF_FFFF};

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r   <= full_w[70:32];
      uf2_r <= uf1_r;
    end
  end

  // stage s3: fraction bits and integer shift of y = -m
  swgl_pkg::ex_t ex_r [2*swgl_pkg::EXP_STEPS+1];
  swgl_pkg::pp_t pp_r [swgl_pkg::EXP_STEPS];
  logic [7:0]    negn_w;
  assign negn_w = {1'b0, m_r[38:32]} + {7'd0, (m_r[31:0] != 32'd0)};

  always_ff @(posedge clk) begin
    if (adv) begin
      ex_r[0].f    <= 32'd0 - m_r[31:0];
      ex_r[0].negn <= negn_w[4:0];
      ex_r[0].uf   <= uf2_r || m_r[38] || (negn_w > 8'd32);
      ex_r[0].one  <= (negn_w == 8'd32);
      ex_r[0].acc  <= 64'd0;
    end
  end

  // product chain: each factor takes a multiply stage and an accumulate stage
  for (genvar gi = 0; gi < swgl_pkg::EXP_STEPS; gi++) begin : g_exp
    logic [127:0]  prod_w;
    swgl_pkg::ex_t ex_nxt;

    always_ff @(posedge clk) begin
      if (adv) begin
        ex_r[2*gi+1] <= ex_r[2*gi];
        pp_r[gi]     <= swgl_pkg::mul_parts(ex_r[2*gi].acc, swgl_pkg::EXP2_FRAC[gi]);
      end
    end

    assign prod_w = swgl_pkg::pp_sum(pp_r[gi]);

    always_comb begin
      ex_nxt = ex_r[2*gi+1];
      if (ex_r[2*gi+1].f[31-gi]) begin
        ex_nxt.acc = ex_r[2*gi+1].acc + swgl_pkg::EXP2_FRAC[gi] + prod_w[127:64];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ex_r[2*gi+2] <= ex_nxt;
      end
    end
  end

  // stage e: scale by the integer part
  swgl_pkg::ex_t ex_end;
  logic [5:0]    sh_w;
  logic [63:0]   escl_w;
  logic [32:0]   e_r;
  assign ex_end = ex_r[2*swgl_pkg::EXP_STEPS];
  assign sh_w   = 6'd32 + {1'b0, ex_end.negn};
  assign escl_w = (ex_end.acc >> sh_w) + (64'd1 << (6'd32 - {1'b0, ex_end.negn}));

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ex_end.uf) begin
        e_r <= 33'd0;
      end else if (ex_end.one) begin
        e_r <= 33'd1;
      end else begin
        e_r <= escl_w[32:0];
      end
    end
  end

  // stage di: divisor 2^32 + e, numerator 2^64 or e * 2^32
  swgl_pkg::dv_t dv_r [swgl_pkg::DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0].d <= {1'b0, e_r} + {2'd1, 32'd0};
      if (cm_r[ST_E].zneg) begin
        dv_r[0].rem <= {1'b0, e_r, 32'd0};
      end else begin
        dv_r[0].rem <= {2'b01, 64'd0};
      end
      dv_r[0].q <= 33'd0;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar gj = 0; gj < swgl_pkg::DIV_STEPS; gj++) begin : g_div
    logic [65:0]   dsh_w;
    swgl_pkg::dv_t dv_nxt;
    assign dsh_w = {32'd0, dv_r[gj].d} << (swgl_pkg::DIV_STEPS - 1 - gj);

    always_comb begin
      dv_nxt = dv_r[gj];
      if (dv_r[gj].rem >= dsh_w) begin
        dv_nxt.rem = dv_r[gj].rem - dsh_w;
        dv_nxt.q[swgl_pkg::DIV_STEPS-1-gj] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[gj+1] <= dv_nxt;
      end
    end
  end

  // stage m1: |z| * sigmoid, partial products
  logic [32:0] sig_w;
  logic [63:0] pa_r;
  logic [62:0] pb_r;
  logic        s1_r;
  assign sig_w = dv_r[swgl_pkg::DIV_STEPS].q;

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r <= {32'd0, cm_r[ST_DIV+swgl_pkg::DIV_STEPS-1].zmag[31:0]} * {32'd0, sig_w[31:0]};
      pb_r <= {32'd0, cm_r[ST_DIV+swgl_pkg::DIV_STEPS-1].zmag[62:32]} * {31'd0, sig_w[31:0]};
      s1_r <= sig_w[32];
    end
  end

  // stage m2: q32 scaling, ceiling for a negative gate
  logic [95:0] zs_w;
  logic [63:0] szmag_r;
  assign zs_w = {32'd0, pa_r} + {1'd0, pb_r, 32'd0}
              + (s1_r ? {1'd0, cm_r[ST_M1].zmag, 32'd0} : 96'd0)
              + (cm_r[ST_M1].zneg ? {64'd0, 32'hFFFF_FFFF} : 96'd0);

  always_ff @(posedge clk) begin
    if (adv) begin
      szmag_r <= zs_w[95:32];
    end
  end

  // stage m3: silu * |u| partial products
  swgl_pkg::pp_t pp2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      pp2_r <= swgl_pkg::mul_parts(szmag_r, cm_r[ST_M2].umag);
    end
  end

  // stage m4: full product
  logic [127:0] prod_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= swgl_pkg::pp_sum(pp2_r);
    end
  end

  // stage m5: q24 scaling, range check and sign
  logic         negres_w;
  logic [127:0] rnd_w;
  logic         err_w;
  logic [63:0]  res_r;
  logic         err_r;
  assign negres_w = cm_r[ST_M4].zneg ^ cm_r[ST_M4].uneg;
  assign rnd_w    = prod_r + (negres_w ? {104'd0, 24'hFF_FFFF} : 128'd0);
  assign err_w    = cm_r[ST_M4].zerr || (rnd_w[127:88] != 40'd0) || rnd_w[87];

  always_ff @(posedge clk) begin
    if (adv) begin
      err_r <= err_w;
      if (err_w) begin
        res_r <= 64'd0;
      end else if (negres_w) begin
        res_r <= 64'd0 - rnd_w[87:24];
      end else begin
        res_r <= rnd_w[87:24];
      end
    end
  end

  assign out_valid       = vld_r[ST_M5];
  assign out_gated_value = res_r;
  assign out_range_error = err_r;
  assign out_last_out    = cm_r[ST_M5].last;

endmodule

`default_nettype wire

// ===== src/swgl_checker.sv =====
`default_nettype none

module swgl_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_gated_value,
  input wire logic        out_range_error,
  input wire logic        out_last_out
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_gated_value)
      && $stable(out_range_error) && $stable(out_last_out))
    else $error("held result beat changed");

  // a stalled output stops the input side
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

  // error beats carry zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_gated_value == 64'd0)
    else $error("error beat with non-zero value");

  // good results stay inside the symmetric range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_range_error |-> out_gated_value != {1'b1, 63'd0})
    else $error("result outside range");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat straight after reset");

endmodule

bind swiglu_gate_fixed_point swgl_checker u_swgl_checker (.*);

`default_nettype wire
